// ===== design/gld_pkg.sv =====
// gif lzw decoder package: constants, status and operation codes, command and status structs
// no dependencies
`default_nettype none
package gld_pkg;
  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_ENTRIES = 4096;
  localparam int STACK_DEPTH = 4096;
  localparam int RESERVOIR_BYTES = 4;
  localparam int RES_BITS = RESERVOIR_BYTES * 8;
  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int HW = $clog2(RES_BITS + 1);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FEED = 2'd1;
  localparam logic [1:0] OP_PULL = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NEED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_END = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;
  localparam logic [2:0] ST_CORRUPT = 3'd5;

  typedef struct packed {
    logic       start;     // restart image
    logic       feed;      // take data byte
    logic       extract;   // take one code from reservoir
    logic       begin_walk;// start walk; kwk case pushes first char
    logic       walk_step; // push suffix, follow prefix
    logic       finish;    // push root, update table
    logic       pop;       // pop one stack entry
    logic       halt;
    logic [2:0] halt_code;
    logic       first;     // accept code as first of run
  } cmd_t;

  typedef struct packed {
    logic       halted;
    logic [2:0] halt_status;
    logic       data_ended;
    logic       stack_empty;
    logic       have_bits;
    logic       is_clear;
    logic       is_end;
    logic       awaiting_first;
    logic       first_bad;     // first code above end code
    logic       code_bad;      // code above next free
    logic       kwk;           // code equals next free
    logic       walk_done;     // walk below clear
    logic       walk_bad;      // invalid chain node
    logic       stack_full;
    logic       sub_zero;      // at length byte
    logic       res_full;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/gld_if.sv =====
// valid/ready stream interfaces for the gif lzw decoder
// depends on nothing
`default_nettype none
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  modport source(output valid, operation, data_byte, input ready);
  modport sink(input valid, operation, data_byte, output ready);
endinterface

interface gld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_index;
  logic [2:0] status;
  modport source(output valid, pixel_index, status, input ready);
  modport sink(input valid, pixel_index, status, output ready);
endinterface
`default_nettype wire

// ===== design/gld_ram.sv =====
// generic single-port-write, one-read ram with registered read data
// no dependencies
`default_nettype none
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/gld_datapath.sv =====
// gif lzw decoder datapath: reservoir, code registers, table and stack memories
// depends on gld_pkg and gld_ram
`default_nettype none
module gld_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gld_pkg::cmd_t  cmd,
  input  wire logic [3:0]     min_code_size,
  input  wire logic [7:0]     data_byte,
  output gld_pkg::stat_t      stat,
  output logic [7:0]          pixel
);
  localparam int TAW = gld_pkg::TAW;
  localparam int SAW = gld_pkg::SAW;
  localparam int HW = gld_pkg::HW;
  localparam int RB = gld_pkg::RES_BITS;

  logic [RB-1:0]  reservoir;
  logic [HW-1:0]  bits_held;
  logic [7:0]     subblock_left;
  logic           data_ended, halted, awaiting_first;
  logic [2:0]     halt_status;
  logic [3:0]     active_min, code_width;
  logic [TAW:0]   next_free, width_limit;
  logic [7:0]     first_char;
  logic [TAW-1:0] previous_code, cur_code, walk;
  logic [SAW:0]   stack_count;

  logic [TAW:0]   clear_code, end_code;
  logic [TAW-1:0] code_raw;
  logic [TAW-1:0] pre_rd;
  logic [7:0]     suf_rd, stk_rd;
  logic           stk_we;
  logic [7:0]     stk_wd;
  logic [SAW-1:0] stk_raddr;
  logic           tbl_we;
  logic [3:0]     m_in;
  logic           m_ok;

  assign clear_code = (TAW+1)'(1) << active_min;
  assign end_code = clear_code + (TAW+1)'(1);
  assign code_raw = reservoir[TAW-1:0] & ((TAW'(1) << code_width) - TAW'(1));
  assign m_in = min_code_size;
  assign m_ok = (m_in >= 4'd1) && (m_in <= 4'd8);

  // walk reads the table at the current node; memories have registered read
  gld_ram #(.WIDTH(TAW), .DEPTH(gld_pkg::TABLE_ENTRIES)) u_prefix (
    .clk(clk), .we(tbl_we), .waddr(next_free[TAW-1:0]), .wdata(previous_code),
    .raddr(walk), .rdata(pre_rd));
  gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::TABLE_ENTRIES)) u_suffix (
    .clk(clk), .we(tbl_we), .waddr(next_free[TAW-1:0]), .wdata(walk[7:0]),
    .raddr(walk), .rdata(suf_rd));
  gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stack_count[SAW-1:0]), .wdata(stk_wd),
    .raddr(stk_raddr), .rdata(stk_rd));

  assign stk_raddr = stack_count[SAW-1:0] - SAW'(1);
  assign tbl_we = cmd.finish && !stat.stack_full && (next_free < (TAW+1)'(gld_pkg::TABLE_ENTRIES));

  always_comb begin
    stk_we = 1'b0;
    stk_wd = first_char;
    if (!stat.stack_full) begin
      if (cmd.begin_walk && stat.kwk) begin
        stk_we = 1'b1;
        stk_wd = first_char;
      end else if (cmd.walk_step) begin
        stk_we = 1'b1;
        stk_wd = suf_rd;
      end else if (cmd.finish) begin
        stk_we = 1'b1;
        stk_wd = walk[7:0];
      end
    end
  end

  // first code of a run is a root and goes out directly
  assign pixel = cmd.first ? cur_code[7:0] : stk_rd;

  always_comb begin
    stat.halted = halted;
    stat.halt_status = halt_status;
    stat.data_ended = data_ended;
    stat.stack_empty = (stack_count == '0);
    stat.have_bits = (bits_held >= HW'(code_width));
    stat.is_clear = ({1'b0, code_raw} == clear_code);
    stat.is_end = ({1'b0, code_raw} == end_code);
    stat.awaiting_first = awaiting_first;
    stat.first_bad = ({1'b0, code_raw} > end_code);
    stat.code_bad = ({1'b0, cur_code} > next_free);
    stat.kwk = ({1'b0, cur_code} == next_free);
    stat.walk_done = ({1'b0, walk} < clear_code);
    stat.walk_bad = ({1'b0, walk} <= end_code) || ({1'b0, walk} >= next_free);
    stat.stack_full = (stack_count >= (SAW+1)'(gld_pkg::STACK_DEPTH));
    stat.sub_zero = (subblock_left == 8'd0);
    stat.res_full = (bits_held > HW'(RB - 8));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      reservoir <= '0;
      bits_held <= '0;
      subblock_left <= '0;
      data_ended <= 1'b0;
      first_char <= '0;
      previous_code <= '0;
      halted <= rst ? 1'b0 : !m_ok;
      halt_status <= (rst || m_ok) ? gld_pkg::ST_OK : gld_pkg::ST_CORRUPT;
      active_min <= (rst || !m_ok) ? 4'd8 : m_in;
      code_width <= (rst || !m_ok) ? 4'd9 : m_in + 4'd1;
      next_free <= ((TAW+1)'(1) << ((rst || !m_ok) ? 4'd8 : m_in)) + (TAW+1)'(2);
      width_limit <= (TAW+1)'(2) << ((rst || !m_ok) ? 4'd8 : m_in);
      stack_count <= '0;
      awaiting_first <= 1'b1;
    end else begin
      if (cmd.halt) begin
        halted <= 1'b1;
        halt_status <= cmd.halt_code;
      end
      if (cmd.feed) begin
        if (stat.sub_zero) begin
          if (data_byte == 8'd0) data_ended <= 1'b1;
          else subblock_left <= data_byte;
        end else begin
          reservoir <= reservoir | (RB'(data_byte) << bits_held);
          bits_held <= bits_held + HW'(8);
          subblock_left <= subblock_left - 8'd1;
        end
      end
      if (cmd.extract) begin
        reservoir <= reservoir >> code_width;
        bits_held <= bits_held - HW'(code_width);
        cur_code <= code_raw;
        walk <= code_raw;
        if (stat.is_clear) begin
          code_width <= active_min + 4'd1;
          next_free <= clear_code + (TAW+1)'(2);
          width_limit <= clear_code << 1;
          stack_count <= '0;
          awaiting_first <= 1'b1;
        end
      end
      if (cmd.first) begin
        first_char <= cur_code[7:0];
        previous_code <= cur_code;
        awaiting_first <= 1'b0;
      end
      if (cmd.begin_walk && stat.kwk) walk <= previous_code;
      if (cmd.walk_step) walk <= pre_rd;
      if (stk_we) stack_count <= stack_count + (SAW+1)'(1);
      if (cmd.finish) begin
        first_char <= walk[7:0];
        if (tbl_we) begin
          next_free <= next_free + (TAW+1)'(1);
          if ((next_free + (TAW+1)'(1) >= width_limit) &&
              (width_limit < (TAW+1)'(gld_pkg::TABLE_ENTRIES)) &&
              (code_width < 4'(gld_pkg::MAX_CODE_BITS))) begin
            width_limit <= width_limit << 1;
            code_width <= code_width + 4'd1;
          end
        end
        previous_code <= cur_code;
      end
      if (cmd.pop) stack_count <= stack_count - (SAW+1)'(1);
    end
  end
endmodule
`default_nettype wire

// ===== design/gld_ctrl.sv =====
// gif lzw decoder controller: sequences feeds, code extraction, walks and pops
// depends on gld_pkg
`default_nettype none
module gld_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     operation,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          pixel_index,
  output logic [2:0]          status,
  input  wire gld_pkg::stat_t stat,
  input  wire logic [7:0]     pixel,
  output gld_pkg::cmd_t       cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXTRACT = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_WAIT = 4'd4;
  localparam logic [3:0] S_FIRST = 4'd5;
  localparam logic [3:0] S_POP = 4'd6;
  localparam logic [3:0] S_POPRD = 4'd7;
  localparam logic [3:0] S_START = 4'd8;

  logic [3:0] state, state_next;
  logic       res_load, res_pix;
  logic [2:0] res_st;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    res_load = 1'b0;
    res_pix = 1'b0;
    res_st = gld_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (operation)
            gld_pkg::OP_START: begin
              cmd.start = 1'b1;
              state_next = S_START; // halt flag is registered, read in S_START
            end
            gld_pkg::OP_FEED: begin
              res_load = 1'b1;
              if (stat.halted) res_st = stat.halt_status;
              else if (!stat.data_ended) begin
                if (!stat.sub_zero && stat.res_full) res_st = gld_pkg::ST_FULL;
                else cmd.feed = 1'b1;
              end
            end
            gld_pkg::OP_PULL: begin
              if (stat.halted) begin
                res_load = 1'b1;
                res_st = stat.halt_status;
              end else if (!stat.stack_empty) state_next = S_POP;
              else state_next = S_EXTRACT;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_START: begin
        res_load = 1'b1;
        if (stat.halted) res_st = stat.halt_status;
        state_next = S_IDLE;
      end
      S_EXTRACT: begin
        if (!stat.have_bits) begin
          res_load = 1'b1;
          state_next = S_IDLE;
          if (stat.data_ended) begin
            cmd.halt = 1'b1;
            cmd.halt_code = gld_pkg::ST_TRUNC;
            res_st = gld_pkg::ST_TRUNC;
          end else res_st = gld_pkg::ST_NEED;
        end else begin
          cmd.extract = 1'b1;
          if (stat.is_clear) state_next = S_EXTRACT;
          else if (stat.is_end) begin
            cmd.halt = 1'b1;
            cmd.halt_code = gld_pkg::ST_END;
            res_load = 1'b1;
            res_st = gld_pkg::ST_END;
            state_next = S_IDLE;
          end else if (stat.awaiting_first) begin
            if (stat.first_bad) begin
              cmd.halt = 1'b1;
              cmd.halt_code = gld_pkg::ST_CORRUPT;
              res_load = 1'b1;
              res_st = gld_pkg::ST_CORRUPT;
              state_next = S_IDLE;
            end else state_next = S_FIRST;
          end else state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.code_bad || (stat.kwk && stat.stack_full)) begin
          cmd.halt = 1'b1;
          cmd.halt_code = gld_pkg::ST_CORRUPT;
          res_load = 1'b1;
          res_st = gld_pkg::ST_CORRUPT;
          state_next = S_IDLE;
        end else begin
          cmd.begin_walk = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = S_WALK; // table read latency
      S_WALK: begin
        if (stat.walk_done) begin
          if (stat.stack_full) begin
            cmd.halt = 1'b1;
            cmd.halt_code = gld_pkg::ST_CORRUPT;
            res_load = 1'b1;
            res_st = gld_pkg::ST_CORRUPT;
            state_next = S_IDLE;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_POPRD;
          end
        end else if (stat.walk_bad || stat.stack_full) begin
          cmd.halt = 1'b1;
          cmd.halt_code = gld_pkg::ST_CORRUPT;
          res_load = 1'b1;
          res_st = gld_pkg::ST_CORRUPT;
          state_next = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_FIRST: begin
        // first code of a run goes straight out
        cmd.first = 1'b1;
        res_load = 1'b1;
        res_pix = 1'b1;
        state_next = S_IDLE;
      end
      // root was just pushed, wait for the stack read of the new top
      S_POPRD: state_next = S_POP;
      S_POP: begin
        cmd.pop = 1'b1;
        res_load = 1'b1;
        res_pix = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= res_st;
      pixel_index <= res_pix ? pixel : 8'd0;
    end
  end
endmodule
`default_nettype wire

// ===== design/gif_lzw_decoder.sv =====
// gif lzw decoder top level: stream channels, config register, controller and datapath
// depends on gld_pkg, gld_if, gld_ctrl, gld_datapath
//
// usage: the input channel carries one beat per operation (start, feed, pull);
// the output channel returns exactly one beat per input beat with pixel_index
// and status. min_code_size is to be written through cfg_we/cfg_data only
// while idle; the block does not enforce this. it is latched on start. after
// reset the block acts as started with size 8. one beat is in work at a time;
// in_ready drops until its result is taken, so a new beat is accepted in the
// cycle after the result beat at the earliest. feed, halted and unused beats
// answer from idle; start reads the registered halt flag in the start state;
// a pull that pops reads the string stack ram first; other pulls extract a
// code (again after each clear code) and answer if bits lack or it is first
// of a run; else it is checked, walked through the registered prefix/suffix
// ram read, its root pushed and popped. corrupt chains end the walk early.
// a stalled receiver holds the result register; no new beat is accepted.
// the memories need no clearing after reset.
`default_nettype none
module gif_lzw_decoder (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  gld_in_if.sink          in_ch,
  gld_out_if.source       out_ch
);
  logic [3:0]     min_code_size;
  gld_pkg::cmd_t  cmd;
  gld_pkg::stat_t stat;
  logic [7:0]     pixel;

  always_ff @(posedge clk) begin
    if (rst) min_code_size <= 4'd8;
    else if (cfg_we) min_code_size <= cfg_data;
  end

  gld_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .operation(in_ch.operation), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .pixel_index(out_ch.pixel_index), .status(out_ch.status),
    .stat(stat), .pixel(pixel), .cmd(cmd));

  gld_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .min_code_size(min_code_size),
    .data_byte(in_ch.data_byte), .stat(stat), .pixel(pixel));
endmodule
`default_nettype wire

// ===== design/gld_checker.sv =====
// port-level checker for the gif lzw decoder, bound to the top level
// depends on gld_pkg and gld_if
`default_nettype none
module gld_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] pixel_index,
  input wire logic [2:0] status
);
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("beat accepted while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= gld_pkg::ST_CORRUPT) else $error("bad status");
  a_pix_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != gld_pkg::ST_OK |-> pixel_index == 8'd0)
    else $error("pixel set on error");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

bind gif_lzw_decoder gld_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pixel_index(out_ch.pixel_index), .status(out_ch.status));
`default_nettype wire

// ===== sim/gif_lzw_decoder_tb.sv =====
// testbench for gif_lzw_decoder: builds lzw code streams, drives start/feed/pull beats
// and checks every result beat against a decoder model kept in a scoreboard class
// depends on gld_pkg, gld_if and the gif_lzw_decoder rtl
`default_nettype none
module gif_lzw_decoder_tb;

  typedef struct {
    logic [7:0] pix;
    logic [2:0] st;
  } pixel_res_t;

  class lzw_scoreboard;
    logic [11:0] prefix_mem[gld_pkg::TABLE_ENTRIES];
    logic [7:0]  suffix_mem[gld_pkg::TABLE_ENTRIES];
    logic [7:0]  string_mem[gld_pkg::STACK_DEPTH];
    int unsigned depth_used, held, sub_left, width, free_code, limit;
    int unsigned first_pix, prev_code, run_size, size_reg;
    logic [31:0] reservoir;
    bit          data_done, want_first, stopped;
    logic [2:0]  stop_cause;
    pixel_res_t  pending_q[$];
    int          errors;

    function new();
      size_reg = 8;
      errors = 0;
      restart();
    endfunction

    function void set_size(int unsigned v);
      size_reg = v;
    endfunction

    function int busy();
      return pending_q.size();
    endfunction

    function void reset_table();
      width = run_size + 1;
      free_code = (1 << run_size) + 2;
      limit = 2 << run_size;
      depth_used = 0;
      want_first = 1;
    endfunction

    function void restart();
      reservoir = 0;
      held = 0;
      sub_left = 0;
      data_done = 0;
      first_pix = 0;
      prev_code = 0;
      stopped = 0;
      stop_cause = gld_pkg::ST_OK;
      if (size_reg < 1 || size_reg > 8) begin
        run_size = 8;
        reset_table();
        stopped = 1;
        stop_cause = gld_pkg::ST_CORRUPT;
      end else begin
        run_size = size_reg;
        reset_table();
      end
    endfunction

    function logic [2:0] halt_with(logic [2:0] s);
      stopped = 1;
      stop_cause = s;
      return s;
    endfunction

    function bit push_char(int unsigned v);
      if (depth_used >= gld_pkg::STACK_DEPTH) return 0;
      string_mem[depth_used] = v[7:0];
      depth_used++;
      return 1;
    endfunction

    function logic [2:0] decode_pull(output logic [7:0] pix);
      int unsigned clr, endc, code, incode, walk;
      clr = 1 << run_size;
      endc = clr + 1;
      pix = 0;
      if (stopped) return stop_cause;
      if (depth_used > 0) begin
        depth_used--;
        pix = string_mem[depth_used];
        return gld_pkg::ST_OK;
      end
      forever begin
        if (held < width)
          return data_done ? halt_with(gld_pkg::ST_TRUNC) : gld_pkg::ST_NEED;
        code = reservoir & ((32'd1 << width) - 1);
        reservoir = reservoir >> width;
        held -= width;
        if (code == clr) begin
          reset_table();
          continue;
        end
        if (code == endc) return halt_with(gld_pkg::ST_END);
        if (want_first) begin
          if (code > endc) return halt_with(gld_pkg::ST_CORRUPT);
          first_pix = code;
          prev_code = code;
          want_first = 0;
          pix = code[7:0];
          return gld_pkg::ST_OK;
        end
        if (code > free_code) return halt_with(gld_pkg::ST_CORRUPT);
        incode = code;
        walk = code;
        if (code == free_code) begin
          if (!push_char(first_pix)) return halt_with(gld_pkg::ST_CORRUPT);
          walk = prev_code;
        end
        while (walk >= clr) begin
          if (walk <= endc || walk >= gld_pkg::TABLE_ENTRIES || walk >= free_code)
            return halt_with(gld_pkg::ST_CORRUPT);
          if (!push_char(suffix_mem[walk])) return halt_with(gld_pkg::ST_CORRUPT);
          walk = prefix_mem[walk];
        end
        first_pix = walk;
        if (!push_char(walk)) return halt_with(gld_pkg::ST_CORRUPT);
        if (free_code < gld_pkg::TABLE_ENTRIES) begin
          prefix_mem[free_code] = prev_code[11:0];
          suffix_mem[free_code] = first_pix[7:0];
          free_code++;
          if (free_code >= limit && limit < gld_pkg::TABLE_ENTRIES &&
              width < gld_pkg::MAX_CODE_BITS) begin
            limit *= 2;
            width++;
          end
        end
        prev_code = incode;
        depth_used--;
        pix = string_mem[depth_used];
        return gld_pkg::ST_OK;
      end
    endfunction

    function logic [2:0] take_byte(logic [7:0] b);
      if (stopped) return stop_cause;
      if (data_done) return gld_pkg::ST_OK;
      if (sub_left == 0) begin
        if (b == 0) data_done = 1;
        else sub_left = b;
        return gld_pkg::ST_OK;
      end
      if (held + 8 > gld_pkg::RES_BITS) return gld_pkg::ST_FULL;
      reservoir = reservoir | (32'(b) << held);
      held += 8;
      sub_left--;
      return gld_pkg::ST_OK;
    endfunction

    // accepted input beat: predict its result and return the predicted status
    function logic [2:0] note_input(logic [1:0] op, logic [7:0] b);
      pixel_res_t r;
      r.pix = 0;
      r.st = gld_pkg::ST_OK;
      case (op)
        gld_pkg::OP_START: begin
          restart();
          r.st = stopped ? stop_cause : gld_pkg::ST_OK;
        end
        gld_pkg::OP_FEED: r.st = take_byte(b);
        gld_pkg::OP_PULL: r.st = decode_pull(r.pix);
        default: ;
      endcase
      pending_q.push_back(r);
      return r.st;
    endfunction

    function void check_result(logic [7:0] pix, logic [2:0] st);
      pixel_res_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: pix %0d status %0d", pix, st);
        return;
      end
      e = pending_q.pop_front();
      if (pix !== e.pix || st !== e.st) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected pix %0d status %0d, got pix %0d status %0d",
                   e.pix, e.st, pix, st);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1000000;
  localparam int KIND_GOOD = 0;
  localparam int KIND_TRUNC = 1;
  localparam int KIND_BADCODE = 2;
  localparam int KIND_BADFIRST = 3;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [3:0] cfg_data = 0;
  gld_in_if  in_ch();
  gld_out_if out_ch();

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  lzw_scoreboard sb = new();
  int  cycles = 0;
  int  beats_sent = 0;
  bit  no_gaps = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.operation = gld_pkg::OP_START;
    in_ch.data_byte = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.pixel_index, out_ch.status);

  always @(negedge clk)
    out_ch.ready = no_gaps || ($urandom_range(0, 99) >= 24);

  task automatic send(logic [1:0] op, logic [7:0] b, output logic [2:0] st);
    if (!no_gaps && $urandom_range(0, 99) < 24) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.operation = op;
    in_ch.data_byte = b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    st = sb.note_input(op, b);
    beats_sent++;
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic wait_drained();
    while (sb.busy() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_size(logic [3:0] v);
    wait_drained();
    cfg_we = 1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_size(v);
  endtask

  // lzw code stream for one image, packed lsb first into length-prefixed sub-blocks
  function automatic void build_image(int m, int kind, int n, int max_blk, ref logic [7:0] q[$]);
    logic [7:0] raw[$];
    logic [63:0] acc;
    int nb, clr, endc, nf, w, lim, code, k, len;
    bit first;
    acc = 0;
    nb = 0;
    clr = 1 << m;
    endc = clr + 1;
    nf = clr + 2;
    w = m + 1;
    lim = 2 * clr;
    first = 1;
    // leading clears
    repeat ($urandom_range(0, 2)) begin
      acc |= 64'(clr) << nb;
      nb += w;
    end
    for (k = 0; k < n; k++) begin
      if (!first && $urandom_range(0, 99) < 4) begin
        code = clr;
        acc |= 64'(code) << nb;
        nb += w;
        nf = clr + 2;
        w = m + 1;
        lim = 2 * clr;
        first = 1;
      end else begin
        if (first) code = $urandom_range(0, clr - 1);
        else if ($urandom_range(0, 99) < 15 && nf < gld_pkg::TABLE_ENTRIES) code = nf;
        else begin
          code = $urandom_range(0, nf - 1);
          if (code == clr || code == endc) code = $urandom_range(0, clr - 1);
        end
        acc |= 64'(code) << nb;
        nb += w;
        if (first) first = 0;
        else if (nf < gld_pkg::TABLE_ENTRIES) begin
          nf++;
          if (nf >= lim && lim < gld_pkg::TABLE_ENTRIES && w < gld_pkg::MAX_CODE_BITS) begin
            lim *= 2;
            w++;
          end
        end
      end
      while (nb >= 8) begin
        raw.push_back(acc[7:0]);
        acc >>= 8;
        nb -= 8;
      end
    end
    code = -1;
    if (kind == KIND_GOOD) code = endc;
    else if (kind == KIND_BADCODE) code = (nf + 1 < (1 << w)) ? nf + 1 : endc;
    else if (kind == KIND_BADFIRST) begin
      acc |= 64'(clr) << nb;
      nb += w;
      w = m + 1;
      code = endc + 1;
    end
    if (code >= 0) begin
      acc |= 64'(code) << nb;
      nb += w;
    end
    while (nb > 0) begin
      raw.push_back(acc[7:0]);
      acc >>= 8;
      nb = (nb > 8) ? nb - 8 : 0;
    end
    q = {};
    while (raw.size() > 0) begin
      len = $urandom_range(1, max_blk);
      if (len > raw.size()) len = raw.size();
      q.push_back(len[7:0]);
      repeat (len) q.push_back(raw.pop_front());
    end
    q.push_back(8'd0);
  endfunction

  task automatic run_image(int m, int kind, int n, int max_blk, bit hold_off);
    logic [7:0] q[$];
    logic [2:0] st;
    int guard;
    if (sb.size_reg != m) write_size(4'(m));
    send(gld_pkg::OP_START, 8'($urandom), st);
    build_image(m, kind, n, max_blk, q);
    foreach (q[i]) begin
      if (hold_off && i == q.size() / 2) wait_drained();
      if ($urandom_range(0, 99) < 30) send(gld_pkg::OP_PULL, 8'($urandom), st);
      if ($urandom_range(0, 99) < 2) send(OP_SPARE, 8'($urandom), st);
      send(gld_pkg::OP_FEED, q[i], st);
      while (st == gld_pkg::ST_FULL) begin
        send(gld_pkg::OP_PULL, 8'($urandom), st);
        send(gld_pkg::OP_FEED, q[i], st);
      end
    end
    if ($urandom_range(0, 1)) send(gld_pkg::OP_FEED, 8'($urandom), st);
    guard = 0;
    do begin
      send(gld_pkg::OP_PULL, 8'($urandom), st);
      guard++;
    end while (st < gld_pkg::ST_END && guard < 5000);
    send(gld_pkg::OP_PULL, 8'($urandom), st);
  endtask

  initial begin
    logic [2:0] st;
    int img, m, kind;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: idle state, reserved op, data end, bad sizes, reservoir full
    send(OP_SPARE, 8'hff, st);
    send(gld_pkg::OP_PULL, 8'h00, st);
    send(gld_pkg::OP_FEED, 8'h00, st);
    send(gld_pkg::OP_FEED, 8'hff, st);
    send(gld_pkg::OP_PULL, 8'h00, st);
    send(gld_pkg::OP_FEED, 8'h12, st);
    write_size(4'd0);
    send(gld_pkg::OP_START, 8'h00, st);
    send(gld_pkg::OP_PULL, 8'h00, st);
    send(gld_pkg::OP_FEED, 8'h05, st);
    write_size(4'd15);
    send(gld_pkg::OP_START, 8'hff, st);
    write_size(4'd9);
    send(gld_pkg::OP_START, 8'h00, st);
    write_size(4'd2);
    send(gld_pkg::OP_START, 8'h00, st);
    send(gld_pkg::OP_FEED, 8'd8, st);
    send(gld_pkg::OP_FEED, 8'h00, st);
    send(gld_pkg::OP_FEED, 8'hff, st);
    send(gld_pkg::OP_FEED, 8'haa, st);
    send(gld_pkg::OP_FEED, 8'h55, st);
    send(gld_pkg::OP_FEED, 8'h80, st);
    send(gld_pkg::OP_PULL, 8'h00, st);
    run_image(1, KIND_GOOD, 12, 3, 0);
    run_image(8, KIND_GOOD, 10, 255, 0);
    run_image(3, KIND_BADFIRST, 4, 4, 0);
    run_image(4, KIND_BADCODE, 8, 4, 0);
    run_image(2, KIND_TRUNC, 10, 5, 0);
    // random images
    img = 0;
    while (beats_sent < 1100) begin
      m = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      kind = $urandom_range(0, 9);
      kind = (kind < 6) ? KIND_GOOD : (kind < 8) ? KIND_TRUNC :
             (kind < 9) ? KIND_BADCODE : KIND_BADFIRST;
      no_gaps = (img == 3);
      run_image(m, kind, $urandom_range(5, 40), $urandom_range(1, 20), img == 5);
      no_gaps = 0;
      img++;
    end
    while (sb.busy() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
design/gld_pkg.sv
design/gld_if.sv
design/gld_ram.sv
design/gld_datapath.sv
design/gld_ctrl.sv
design/gif_lzw_decoder.sv
design/gld_checker.sv
sim/gif_lzw_decoder_tb.sv
